// ===== sv/tca_pkg.sv =====
package tca_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int SUM_WIDTH_DEF   = 64;
    localparam int MOMENT_SHIFT    = 40;
    localparam int VOLUME_DIVISOR  = 120;
    localparam int COUNT_WIDTH     = 32;
    localparam int QUEUE_DEPTH     = 2;

endpackage

// ===== sv/tca_if.sv =====
interface tca_in_if #(parameter int CW = 16) (input logic clk);
    logic                 valid;
    logic                 ready;
    logic                 start_new;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
    modport source (output valid, start_new, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, start_new, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface tca_out_if #(parameter int SW = 64) (input logic clk);
    logic                 valid;
    logic                 ready;
    logic        [62:0]   sum_xx;
    logic signed [63:0]   sum_xy;
    logic signed [63:0]   sum_xz;
    logic        [62:0]   sum_yy;
    logic signed [63:0]   sum_yz;
    logic        [62:0]   sum_zz;
    logic        [31:0]   tetra_count;
    modport source (output valid, sum_xx, sum_xy, sum_xz, sum_yy, sum_yz, sum_zz,
                    tetra_count, input ready);
    modport sink (input valid, sum_xx, sum_xy, sum_xz, sum_yy, sum_yz, sum_zz,
                  tetra_count, output ready);
endinterface

// ===== sv/tetra_covariance_accumulator.sv =====
// Tetrahedron second-moment accumulator.
// in_ch: one request per tetrahedron (start_new plus corners a, b, c, origin
// as fourth corner). out_ch: one result per request, the six running moment
// sums after the update and the tetrahedron count.
// The front computes the determinant and doubled moments in two stages and
// pushes them into a two-entry queue. The back runs one shared 16-bit digit
// multiplier and a digit-wise reciprocal divider over the six moments, with
// three multiply digit steps, three divide digit steps and one accumulate step
// for each. The back works on one request at a time and takes the next from
// the queue only once out_ch has accepted the last result.
// Reset clears the sums, the count and the pipeline's valid and queue state.
// While out_ch stalls the result holds, the back waits, and the front keeps
// taking requests until the queue fills.
module tetra_covariance_accumulator
    import tca_pkg::*;
#(
    parameter int COORD_WIDTH = tca_pkg::COORD_WIDTH_DEF,
    parameter int SUM_WIDTH   = tca_pkg::SUM_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tca_in_if.sink     in_ch,
    tca_out_if.source  out_ch
);
    logic                               q_valid;
    logic                               q_ready;
    logic                               q_start;
    logic signed [2*COORD_WIDTH+7:0]    q_s2 [6];
    logic        [3*COORD_WIDTH+3:0]    q_det;

    tca_front #(.CW(COORD_WIDTH), .SW(SUM_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_start (q_start),
        .q_s2    (q_s2),
        .q_det   (q_det)
    );

    tca_back #(.CW(COORD_WIDTH), .SW(SUM_WIDTH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_start (q_start),
        .q_s2    (q_s2),
        .q_det   (q_det),
        .out_ch  (out_ch)
    );

endmodule

// ===== sv/tca_front.sv =====
module tca_front #(
    parameter int CW = 16,
    parameter int SW = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    tca_in_if.sink            in_ch,
    output logic              q_valid,
    input  logic              q_ready,
    output logic              q_start,
    output logic signed [2*CW+7:0]   q_s2 [6],
    output logic        [3*CW+3:0]   q_det
);
    import tca_pkg::*;

    localparam int PW = 2 * CW + 8;
    localparam int DW = 3 * CW + 4;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int IDXW = $clog2(QUEUE_DEPTH);

    // stage 0: minors and coordinate sums; stage 1: det terms and s2; then queue
    logic                   s0_valid_reg;
    logic                   s0_start_reg;
    logic signed [CW-1:0]   s0_x_reg [3];
    logic signed [CW-1:0]   s0_y_reg [3];
    logic signed [CW-1:0]   s0_z_reg [3];
    logic signed [2*CW:0]   m_yz_reg;
    logic signed [2*CW:0]   m_xz_reg;
    logic signed [2*CW:0]   m_xy_reg;
    logic signed [CW+1:0]   sx_reg;
    logic signed [CW+1:0]   sy_reg;
    logic signed [CW+1:0]   sz_reg;

    logic                   s1_valid_reg;
    logic                   s1_start_reg;
    logic signed [PW-1:0]   s1_s2_reg [6];
    logic signed [DW-1:0]   s1_det_reg;

    logic                   q_start_mem [QUEUE_DEPTH];
    logic signed [PW-1:0]   q_s2_mem [QUEUE_DEPTH][6];
    logic        [DW-1:0]   q_det_mem [QUEUE_DEPTH];
    logic [IDXW-1:0]        wr_ptr_reg;
    logic [IDXW-1:0]        rd_ptr_reg;
    logic [CNTW-1:0]        cnt_reg;

    logic signed [PW-1:0]   s2_next [6];
    logic signed [DW-1:0]   det_next;
    logic signed [DW-1:0]   t0;
    logic signed [DW-1:0]   t1;
    logic signed [DW-1:0]   t2;
    logic                   push;
    logic                   pop;
    logic [CNTW-1:0]        inflight;
    logic                   adv0;
    logic                   adv1;

    assign pop      = q_valid && q_ready;
    assign inflight = cnt_reg + CNTW'(s0_valid_reg) + CNTW'(s1_valid_reg);
    assign in_ch.ready = (inflight < CNTW'(QUEUE_DEPTH)) || ((inflight == CNTW'(QUEUE_DEPTH)) && pop);
    assign adv0 = 1'b1;
    assign adv1 = 1'b1;
    assign push = s1_valid_reg;

    always_comb
    begin
        t0 = DW'(s0_x_reg[0]) * DW'(m_yz_reg);
        t1 = DW'(s0_y_reg[0]) * DW'(m_xz_reg);
        t2 = DW'(s0_z_reg[0]) * DW'(m_xy_reg);
        det_next = t0 - t1 + t2;
        s2_next[0] = PW'(sx_reg) * PW'(sx_reg) + PW'(s0_x_reg[0]) * PW'(s0_x_reg[0])
                   + PW'(s0_x_reg[1]) * PW'(s0_x_reg[1]) + PW'(s0_x_reg[2]) * PW'(s0_x_reg[2]);
        s2_next[1] = PW'(sx_reg) * PW'(sy_reg) + PW'(s0_x_reg[0]) * PW'(s0_y_reg[0])
                   + PW'(s0_x_reg[1]) * PW'(s0_y_reg[1]) + PW'(s0_x_reg[2]) * PW'(s0_y_reg[2]);
        s2_next[2] = PW'(sx_reg) * PW'(sz_reg) + PW'(s0_x_reg[0]) * PW'(s0_z_reg[0])
                   + PW'(s0_x_reg[1]) * PW'(s0_z_reg[1]) + PW'(s0_x_reg[2]) * PW'(s0_z_reg[2]);
        s2_next[3] = PW'(sy_reg) * PW'(sy_reg) + PW'(s0_y_reg[0]) * PW'(s0_y_reg[0])
                   + PW'(s0_y_reg[1]) * PW'(s0_y_reg[1]) + PW'(s0_y_reg[2]) * PW'(s0_y_reg[2]);
        s2_next[4] = PW'(sy_reg) * PW'(sz_reg) + PW'(s0_y_reg[0]) * PW'(s0_z_reg[0])
                   + PW'(s0_y_reg[1]) * PW'(s0_z_reg[1]) + PW'(s0_y_reg[2]) * PW'(s0_z_reg[2]);
        s2_next[5] = PW'(sz_reg) * PW'(sz_reg) + PW'(s0_z_reg[0]) * PW'(s0_z_reg[0])
                   + PW'(s0_z_reg[1]) * PW'(s0_z_reg[1]) + PW'(s0_z_reg[2]) * PW'(s0_z_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (adv0)
                s0_valid_reg <= in_ch.valid && in_ch.ready;
            if (adv1)
                s1_valid_reg <= s0_valid_reg;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == IDXW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == IDXW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + CNTW'(push) - CNTW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        s0_start_reg <= in_ch.start_new;
        s0_x_reg[0] <= in_ch.a_x;
        s0_x_reg[1] <= in_ch.b_x;
        s0_x_reg[2] <= in_ch.c_x;
        s0_y_reg[0] <= in_ch.a_y;
        s0_y_reg[1] <= in_ch.b_y;
        s0_y_reg[2] <= in_ch.c_y;
        s0_z_reg[0] <= in_ch.a_z;
        s0_z_reg[1] <= in_ch.b_z;
        s0_z_reg[2] <= in_ch.c_z;
        m_yz_reg <= (2*CW+1)'(in_ch.b_y * in_ch.c_z) - (2*CW+1)'(in_ch.c_y * in_ch.b_z);
        m_xz_reg <= (2*CW+1)'(in_ch.b_x * in_ch.c_z) - (2*CW+1)'(in_ch.c_x * in_ch.b_z);
        m_xy_reg <= (2*CW+1)'(in_ch.b_x * in_ch.c_y) - (2*CW+1)'(in_ch.c_x * in_ch.b_y);
        sx_reg <= (CW+2)'(in_ch.a_x) + (CW+2)'(in_ch.b_x) + (CW+2)'(in_ch.c_x);
        sy_reg <= (CW+2)'(in_ch.a_y) + (CW+2)'(in_ch.b_y) + (CW+2)'(in_ch.c_y);
        sz_reg <= (CW+2)'(in_ch.a_z) + (CW+2)'(in_ch.b_z) + (CW+2)'(in_ch.c_z);
        s1_start_reg <= s0_start_reg;
        s1_s2_reg    <= s2_next;
        s1_det_reg   <= det_next;
        if (push)
        begin
            q_start_mem[wr_ptr_reg] <= s1_start_reg;
            q_s2_mem[wr_ptr_reg]    <= s1_s2_reg;
            q_det_mem[wr_ptr_reg]   <= s1_det_reg[DW-1] ? DW'(-s1_det_reg) : DW'(s1_det_reg);
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_start = q_start_mem[rd_ptr_reg];
    assign q_s2    = q_s2_mem[rd_ptr_reg];
    assign q_det   = q_det_mem[rd_ptr_reg];

endmodule

// ===== sv/tca_back.sv =====
module tca_back #(
    parameter int CW = 16,
    parameter int SW = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  logic                    q_start,
    input  logic signed [2*CW+7:0]  q_s2 [6],
    input  logic        [3*CW+3:0]  q_det,
    tca_out_if.source               out_ch
);
    import tca_pkg::*;

    localparam int PW   = 2 * CW + 8;
    localparam int AW   = 2 * CW + 4;
    localparam int LW   = 16;
    localparam int ND   = (3 * CW + LW - 1) / LW;
    localparam int DDW  = ND * LW;
    localparam int MW   = AW + DDW;
    localparam int SHW  = MW - MOMENT_SHIFT;
    localparam int NQ   = (SHW + LW - 1) / LW;
    localparam int QW   = NQ * LW;
    localparam int RW   = $clog2(VOLUME_DIVISOR);
    localparam int CURW = RW + LW;
    localparam int RSH  = CURW + RW;
    localparam int RCW  = RSH - RW + 1;
    localparam int EW   = ((QW > SW) ? QW : SW) + 1;
    // rounded-up reciprocal, exact floor for every digit step operand
    localparam logic [RCW-1:0] RECIP =
        RCW'(((64'(1) << RSH) + 64'(VOLUME_DIVISOR) - 64'(1)) / 64'(VOLUME_DIVISOR));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]               state_reg;
    logic [2:0]               idx_reg;
    logic [2:0]               step_reg;
    logic signed [PW-1:0]     s2_reg [6];
    logic [DDW-1:0]           det_reg;
    logic [DDW-1:0]           dsh_reg;
    logic [MW-1:0]            prod_reg;
    logic [QW-1:0]            div_reg;
    logic [QW-1:0]            quo_reg;
    logic [RW-1:0]            rem_reg;
    logic signed [SW-1:0]     sum_reg [6];
    logic [COUNT_WIDTH-1:0]   cnt_reg;

    logic signed [PW-1:0]     s2_cur;
    logic                     neg;
    logic [AW-1:0]            mag;
    logic [AW+LW-1:0]         pp;
    logic [MW-1:0]            prod_next;
    logic                     mul_last;
    logic                     div_last;
    logic [CURW-1:0]          cur;
    logic [CURW+RCW-1:0]      cur_scaled;
    logic [LW-1:0]            qd;
    logic [CURW-1:0]          rem_wide;
    logic [EW-1:0]            q_ext;
    logic [EW-1:0]            lim;
    logic [SW:0]              inc_mag;
    logic signed [SW:0]       inc;
    logic signed [SW+1:0]     acc;
    logic signed [SW-1:0]     maxv;
    logic signed [SW-1:0]     minv;

    assign s2_cur     = s2_reg[idx_reg];
    assign neg        = s2_cur[PW-1];
    assign mag        = neg ? AW'(-s2_cur) : AW'(s2_cur);
    assign pp         = (AW+LW)'(mag) * (AW+LW)'(dsh_reg[DDW-1 -: LW]);
    assign prod_next  = (prod_reg << LW) + MW'(pp);
    assign mul_last   = (step_reg == 3'(ND - 1));
    assign div_last   = (step_reg == 3'(NQ - 1));

    assign cur        = {rem_reg, div_reg[QW-1 -: LW]};
    assign cur_scaled = (CURW+RCW)'(cur) * (CURW+RCW)'(RECIP);
    assign qd         = LW'(cur_scaled >> RSH);
    assign rem_wide   = cur - CURW'(qd) * CURW'(VOLUME_DIVISOR);

    assign maxv    = {1'b0, {(SW-1){1'b1}}};
    assign minv    = {1'b1, {(SW-1){1'b0}}};
    assign q_ext   = EW'(quo_reg);
    assign lim     = neg ? EW'(maxv) + EW'(1) : EW'(maxv);
    assign inc_mag = (q_ext > lim) ? (SW+1)'(lim) : (SW+1)'(q_ext);
    assign inc     = neg ? -$signed(inc_mag) : $signed(inc_mag);
    assign acc     = (SW+2)'(sum_reg[idx_reg]) + (SW+2)'(inc);

    assign q_ready      = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < 6; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        idx_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                        if (q_start)
                        begin
                            cnt_reg <= '0;
                            for (int i = 0; i < 6; i++)
                                sum_reg[i] <= '0;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mul_last)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_DIV:
                begin
                    if (div_last)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_ACC;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_ACC:
                begin
                    if (acc > (SW+2)'(maxv))
                        sum_reg[idx_reg] <= maxv;
                    else if (acc < (SW+2)'(minv))
                        sum_reg[idx_reg] <= minv;
                    else
                        sum_reg[idx_reg] <= SW'(acc);
                    if (idx_reg == 3'd5)
                    begin
                        if (cnt_reg != '1)
                            cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT:
                    if (out_ch.ready)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            s2_reg   <= q_s2;
            det_reg  <= DDW'(q_det);
            dsh_reg  <= DDW'(q_det);
            prod_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
            dsh_reg  <= dsh_reg << LW;
            if (mul_last)
            begin
                div_reg <= QW'(prod_next >> MOMENT_SHIFT);
                rem_reg <= '0;
                quo_reg <= '0;
            end
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= RW'(rem_wide);
            quo_reg <= (quo_reg << LW) | QW'(qd);
            div_reg <= div_reg << LW;
        end
        if (state_reg == ST_ACC)
        begin
            prod_reg <= '0;
            dsh_reg  <= det_reg;
        end
    end

    assign out_ch.sum_xx      = 63'(sum_reg[0]);
    assign out_ch.sum_xy      = 64'(sum_reg[1]);
    assign out_ch.sum_xz      = 64'(sum_reg[2]);
    assign out_ch.sum_yy      = 63'(sum_reg[3]);
    assign out_ch.sum_yz      = 64'(sum_reg[4]);
    assign out_ch.sum_zz      = 63'(sum_reg[5]);
    assign out_ch.tetra_count = cnt_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tca_pkg::*;

    typedef struct {
        logic                    start_new;
        logic signed [15:0]      crd [9];
    } tetra_t;

    typedef struct {
        logic signed [63:0]      sums [6];
        logic [31:0]             count;
    } moments_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tca_in_if  #(.CW(16)) in_ch  (clk);
    tca_out_if #(.SW(64)) out_ch (clk);

    tetra_covariance_accumulator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tetra_t      pending_tetra [$];
    moments_t    expected_moments [$];
    tetra_t      offered;
    logic signed [63:0] run_sums [6];
    logic [31:0] run_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          errors = 0;
    longint      cycles = 0;
    bit          in_taken = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic void accumulate_tetra(input tetra_t t, output moments_t m);
        longint x [3];
        longint y [3];
        longint z [3];
        longint s2 [6];
        longint det;
        logic [127:0] absdet;
        logic [127:0] ms;
        logic [127:0] q;
        logic [127:0] lim;
        logic signed [65:0] inc;
        logic signed [65:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            x[i] = 64'(t.crd[3*i]);
            y[i] = 64'(t.crd[3*i+1]);
            z[i] = 64'(t.crd[3*i+2]);
        end
        if (t.start_new)
        begin
            foreach (run_sums[i]) run_sums[i] = '0;
            run_count = '0;
        end
        det = x[0] * (y[1] * z[2] - y[2] * z[1]) - y[0] * (x[1] * z[2] - x[2] * z[1])
            + z[0] * (x[1] * y[2] - x[2] * y[1]);
        absdet = (det < 0) ? 128'(-det) : 128'(det);
        s2[0] = (x[0]+x[1]+x[2])*(x[0]+x[1]+x[2]) + x[0]*x[0] + x[1]*x[1] + x[2]*x[2];
        s2[1] = (x[0]+x[1]+x[2])*(y[0]+y[1]+y[2]) + x[0]*y[0] + x[1]*y[1] + x[2]*y[2];
        s2[2] = (x[0]+x[1]+x[2])*(z[0]+z[1]+z[2]) + x[0]*z[0] + x[1]*z[1] + x[2]*z[2];
        s2[3] = (y[0]+y[1]+y[2])*(y[0]+y[1]+y[2]) + y[0]*y[0] + y[1]*y[1] + y[2]*y[2];
        s2[4] = (y[0]+y[1]+y[2])*(z[0]+z[1]+z[2]) + y[0]*z[0] + y[1]*z[1] + y[2]*z[2];
        s2[5] = (z[0]+z[1]+z[2])*(z[0]+z[1]+z[2]) + z[0]*z[0] + z[1]*z[1] + z[2]*z[2];
        for (int i = 0; i < 6; i++)
        begin
            ms  = (s2[i] < 0) ? 128'(-s2[i]) : 128'(s2[i]);
            q   = ((ms * absdet) >> MOMENT_SHIFT) / VOLUME_DIVISOR;
            lim = (s2[i] < 0) ? (128'(1) << 63) : ((128'(1) << 63) - 1);
            if (q > lim)
                q = lim;
            inc = (s2[i] < 0) ? -$signed({1'b0, q[64:0]}) : $signed({1'b0, q[64:0]});
            acc = 66'(run_sums[i]) + inc;
            if (acc > 66'sh0_7FFF_FFFF_FFFF_FFFF)
                acc = 66'sh0_7FFF_FFFF_FFFF_FFFF;
            else if (acc < -66'sh0_8000_0000_0000_0000)
                acc = -66'sh0_8000_0000_0000_0000;
            run_sums[i] = acc[63:0];
            m.sums[i] = run_sums[i];
        end
        if (run_count != 32'hFFFF_FFFF)
            run_count++;
        m.count = run_count;
    endfunction

    always @(posedge clk)
    begin
        moments_t want;
        moments_t got;
        cycles++;
        if (cycles > 2000000)
        begin
            $display("timeout");
            $display("FAIL tetra_covariance_accumulator");
            $finish;
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            accumulate_tetra(offered, want);
            expected_moments.insert(expected_moments.size(), want);
            in_taken = 1'b1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_moments.size() == 0)
            begin
                report("unexpected result", 64'(out_ch.tetra_count), 64'd0);
            end
            else
            begin
                want = expected_moments.pop_front();
                got.sums[0] = {1'b0, out_ch.sum_xx};
                got.sums[1] = out_ch.sum_xy;
                got.sums[2] = out_ch.sum_xz;
                got.sums[3] = {1'b0, out_ch.sum_yy};
                got.sums[4] = out_ch.sum_yz;
                got.sums[5] = {1'b0, out_ch.sum_zz};
                want.sums[0][63] = 1'b0;
                want.sums[3][63] = 1'b0;
                want.sums[5][63] = 1'b0;
                for (int i = 0; i < 6; i++)
                    if (got.sums[i] !== want.sums[i])
                        report($sformatf("sum %0d", i), got.sums[i], want.sums[i]);
                if (out_ch.tetra_count !== want.count)
                    report("tetra_count", 64'(out_ch.tetra_count), 64'(want.count));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid = 1'b0;
        end
        else if (!(in_ch.valid && !in_taken))
        begin
            if (pending_tetra.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offered = pending_tetra.pop_front();
                in_ch.valid     = 1'b1;
                in_ch.start_new = offered.start_new;
                in_ch.a_x = offered.crd[0];
                in_ch.a_y = offered.crd[1];
                in_ch.a_z = offered.crd[2];
                in_ch.b_x = offered.crd[3];
                in_ch.b_y = offered.crd[4];
                in_ch.b_z = offered.crd[5];
                in_ch.c_x = offered.crd[6];
                in_ch.c_y = offered.crd[7];
                in_ch.c_z = offered.crd[8];
            end
            else
            begin
                in_ch.valid = 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
        begin
            out_ch.ready = rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_tetra(input logic s, input logic signed [15:0] c [9]);
        tetra_t t;
        t.start_new = s;
        t.crd = c;
        pending_tetra.insert(pending_tetra.size(), t);
    endtask

    task automatic queue_random(input int n);
        logic signed [15:0] c [9];
        int shape;
        for (int k = 0; k < n; k++)
        begin
            shape = $urandom_range(9);
            foreach (c[i])
            begin
                if (shape < 5)
                    c[i] = 16'($urandom_range(65535));
                else if (shape < 8)
                    c[i] = 16'($signed($urandom_range(2000)) - 1000);
                else
                    c[i] = ($urandom_range(1)) ? 16'sh7FFF - 16'($urandom_range(3))
                                               : -16'sh8000 + 16'($urandom_range(3));
            end
            if (shape == 9 && $urandom_range(1))
            begin
                for (int i = 0; i < 3; i++)
                    c[6+i] = c[i] + c[3+i];
            end
            queue_tetra($urandom_range(19) == 0, c);
        end
    endtask

    task automatic drain;
        while (pending_tetra.size() != 0 || expected_moments.size() != 0 || in_ch.valid)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [15:0] c [9];
        in_ch.valid = 1'b0;
        in_ch.start_new = 1'b0;
        in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
        in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
        in_ch.c_x = '0; in_ch.c_y = '0; in_ch.c_z = '0;
        out_ch.ready = 1'b0;
        foreach (run_sums[i]) run_sums[i] = '0;
        run_count = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (c[i]) c[i] = 16'sh7FFF;
        queue_tetra(1'b0, c);
        foreach (c[i]) c[i] = -16'sh8000;
        queue_tetra(1'b0, c);
        foreach (c[i]) c[i] = '0;
        queue_tetra(1'b1, c);
        c[0] = 16'sh7FFF; c[4] = 16'sh7FFF; c[8] = 16'sh7FFF;
        queue_tetra(1'b0, c);
        c[0] = -16'sh8000; c[4] = -16'sh8000; c[8] = -16'sh8000;
        queue_tetra(1'b0, c);
        c[4] = 16'sh7FFF;
        queue_tetra(1'b1, c);
        c = '{16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0,
              16'sh0, 16'sh0, 16'sh4000};
        queue_tetra(1'b1, c);
        c = '{-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
              -16'sh8000, -16'sh8000, 16'sh7FFF};
        queue_tetra(1'b0, c);
        c = '{16'sh100, 16'sh200, 16'sh300, 16'sh200, 16'sh400, 16'sh600,
              -16'sh7, 16'sh5, 16'sh3};
        queue_tetra(1'b0, c);
        c = '{16'sh1, 16'sh0, 16'sh0, 16'sh0, 16'sh1, 16'sh0, 16'sh0, 16'sh0, -16'sh1};
        queue_tetra(1'b0, c);
        queue_random(240);
        drain();

        send_idle_pct = 62;
        queue_random(270);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 62;
        queue_random(270);
        drain();

        send_idle_pct = 16;
        recv_stall_pct = 16;
        hold_cycles = 400;
        queue_random(290);
        drain();

        repeat (60) @(posedge clk);
        if (errors == 0 && expected_moments.size() == 0)
            $display("PASS tetra_covariance_accumulator");
        else
            $display("FAIL tetra_covariance_accumulator");
        $finish;
    end

endmodule
